// ===== hw/rtl/mccf_pkg.sv =====
package mccf_pkg;

  typedef enum logic [2:0] {
    PH_FETCH  = 3'd0,
    PH_DECODE = 3'd1,
    PH_EXEC   = 3'd2,
    PH_MEM    = 3'd3,
    PH_WB     = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    ALU_NONE = 4'd0,
    ALU_ADD  = 4'd1,
    ALU_SUB  = 4'd2,
    ALU_AND  = 4'd3,
    ALU_OR   = 4'd4,
    ALU_XOR  = 4'd5,
    ALU_NOR  = 4'd6,
    ALU_SLT  = 4'd7,
    ALU_LTU  = 4'd8,
    ALU_SLL  = 4'd9,
    ALU_SRL  = 4'd10,
    ALU_SRA  = 4'd11,
    ALU_LUI  = 4'd12,
    ALU_EQ   = 4'd13,
    ALU_NEQ  = 4'd14
  } alu_op_e;

  localparam logic [1:0] SRCB_B     = 2'd0;
  localparam logic [1:0] SRCB_FOUR  = 2'd1;
  localparam logic [1:0] SRCB_IMM   = 2'd2;
  localparam logic [1:0] SRCB_IMMSH = 2'd3;

  localparam logic [1:0] PCU_NONE   = 2'd0;
  localparam logic [1:0] PCU_ALWAYS = 2'd1;
  localparam logic [1:0] PCU_BRANCH = 2'd2;

  localparam logic [1:0] PCS_ALU    = 2'd0;
  localparam logic [1:0] PCS_ALUOUT = 2'd1;
  localparam logic [1:0] PCS_JUMP   = 2'd2;
  localparam logic [1:0] PCS_REG    = 2'd3;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [1:0] RT_NONE = 2'd0;
  localparam logic [1:0] RT_RT   = 2'd1;
  localparam logic [1:0] RT_RD   = 2'd2;
  localparam logic [1:0] RT_RA   = 2'd3;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADD_IMM = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_LTU_IMM = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  typedef struct packed {
    phase_e     phase;
    logic       ir_write;
    logic       alu_src_a;
    logic [1:0] alu_src_b;
    alu_op_e    alu_op;
    logic [1:0] pc_update;
    logic [1:0] pc_source;
    logic       addr_from_alu;
    logic [1:0] mem_access;
    logic [1:0] reg_target;
    logic       write_from_mem;
    logic       sign_extend;
  } ctrl_t;

  function automatic alu_op_e rtype_alu(input logic [5:0] fn);
    alu_op_e r;
    unique case (fn)
      FN_SLL:  r = ALU_SLL;
      FN_SRL:  r = ALU_SRL;
      FN_SRA:  r = ALU_SRA;
      FN_ADDU: r = ALU_ADD;
      FN_SUBU: r = ALU_SUB;
      FN_AND:  r = ALU_AND;
      FN_OR:   r = ALU_OR;
      FN_XOR:  r = ALU_XOR;
      FN_NOR:  r = ALU_NOR;
      FN_SLT:  r = ALU_SLT;
      FN_SLTU: r = ALU_LTU;
      default: r = ALU_NONE;
    endcase
    return r;
  endfunction

  function automatic alu_op_e imm_alu(input logic [5:0] op);
    alu_op_e r;
    unique case (op)
      OP_ADD_IMM: r = ALU_ADD;
      OP_SLTI:    r = ALU_SLT;
      OP_LTU_IMM: r = ALU_LTU;
      OP_ANDI:    r = ALU_AND;
      OP_ORI:     r = ALU_OR;
      OP_XORI:    r = ALU_XOR;
      default:    r = ALU_LUI;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/multicycle_cpu_control_fsm.sv =====
// an accepted instruction word's control word is registered and appears on the outputs in the next cycle
// throughput: one word per cycle while the receiver does not stall; the phase register updates on every accepted word
// the output register accepts a new word in the cycle its current word is taken
// reset (rst_ni low, asynchronous): phase returns to fetch, output register empties
module multicycle_cpu_control_fsm
  import mccf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instr_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  phase_o,
  output logic        ir_write_o,
  output logic        alu_src_a_o,
  output logic [1:0]  alu_src_b_o,
  output logic [3:0]  alu_op_o,
  output logic [1:0]  pc_update_o,
  output logic [1:0]  pc_source_o,
  output logic        addr_from_alu_o,
  output logic [1:0]  mem_access_o,
  output logic [1:0]  reg_target_o,
  output logic        write_from_mem_o,
  output logic        sign_extend_o
);

  phase_e     phase_q, phase_d;
  ctrl_t      ctrl_q, ctrl_d;
  logic       out_valid_q;
  logic       in_acc;
  logic [5:0] op;
  logic [5:0] fn;
  logic       is_imm;

  assign op     = instr_word_i[31:26];
  assign fn     = instr_word_i[5:0];
  assign is_imm = (op == OP_ADD_IMM) || (op == OP_SLTI) || (op == OP_LTU_IMM) ||
                  (op == OP_ANDI) || (op == OP_ORI) || (op == OP_XORI) || (op == OP_LUI);

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // next phase
  always_comb begin
    phase_d = PH_FETCH;
    unique case (phase_q)
      PH_FETCH:  phase_d = PH_DECODE;
      PH_DECODE: phase_d = PH_EXEC;
      PH_EXEC: begin
        priority if (op == OP_SPECIAL) begin
          phase_d = (fn == FN_JR) ? PH_FETCH : PH_WB;
        end else if (op == OP_LW || op == OP_SW) begin
          phase_d = PH_MEM;
        end else if (op == OP_JAL || is_imm) begin
          phase_d = PH_WB;
        end else begin
          phase_d = PH_FETCH;
        end
      end
      PH_MEM:  phase_d = (op == OP_LW) ? PH_WB : PH_FETCH;
      default: phase_d = PH_FETCH;
    endcase
  end

  // control word of the current phase
  always_comb begin
    ctrl_d       = '0;
    ctrl_d.phase = phase_q;
    unique case (phase_q)
      PH_FETCH: begin
        ctrl_d.ir_write   = 1'b1;
        ctrl_d.alu_src_b  = SRCB_FOUR;
        ctrl_d.alu_op     = ALU_ADD;
        ctrl_d.pc_update  = PCU_ALWAYS;
        ctrl_d.mem_access = MEM_READ;
      end
      PH_DECODE: begin
        ctrl_d.alu_src_b   = SRCB_IMMSH;
        ctrl_d.alu_op      = ALU_ADD;
        ctrl_d.sign_extend = 1'b1;
      end
      PH_EXEC: begin
        priority if (op == OP_SPECIAL) begin
          ctrl_d.alu_src_a = 1'b1;
          if (fn == FN_JR) begin
            ctrl_d.pc_update = PCU_ALWAYS;
            ctrl_d.pc_source = PCS_REG;
          end else begin
            ctrl_d.alu_op = rtype_alu(fn);
          end
        end else if (op == OP_LW || op == OP_SW) begin
          ctrl_d.alu_src_a   = 1'b1;
          ctrl_d.alu_src_b   = SRCB_IMM;
          ctrl_d.alu_op      = ALU_ADD;
          ctrl_d.sign_extend = 1'b1;
        end else if (op == OP_BEQ || op == OP_BNE) begin
          ctrl_d.alu_src_a   = 1'b1;
          ctrl_d.sign_extend = 1'b1;
          ctrl_d.alu_op      = (op == OP_BEQ) ? ALU_EQ : ALU_NEQ;
          ctrl_d.pc_update   = PCU_BRANCH;
          ctrl_d.pc_source   = PCS_ALUOUT;
        end else if (op == OP_J || op == OP_JAL) begin
          ctrl_d.pc_update = PCU_ALWAYS;
          ctrl_d.pc_source = PCS_JUMP;
        end else if (is_imm) begin
          ctrl_d.alu_src_a   = 1'b1;
          ctrl_d.alu_src_b   = SRCB_IMM;
          ctrl_d.sign_extend = (op == OP_ADD_IMM) || (op == OP_SLTI) || (op == OP_LTU_IMM);
          ctrl_d.alu_op      = imm_alu(op);
        end else begin
          ctrl_d.alu_op = ALU_NONE;
        end
      end
      PH_MEM: begin
        if (op == OP_LW) begin
          ctrl_d.addr_from_alu = 1'b1;
          ctrl_d.mem_access    = MEM_READ;
        end else if (op == OP_SW) begin
          ctrl_d.addr_from_alu = 1'b1;
          ctrl_d.mem_access    = MEM_WRITE;
        end
      end
      PH_WB: begin
        priority if (op == OP_SPECIAL) begin
          ctrl_d.reg_target = (fn != FN_JR) ? RT_RD : RT_NONE;
        end else if (op == OP_LW) begin
          ctrl_d.reg_target     = RT_RT;
          ctrl_d.write_from_mem = 1'b1;
        end else if (op == OP_JAL) begin
          ctrl_d.reg_target = RT_RA;
        end else if (is_imm) begin
          ctrl_d.reg_target = RT_RT;
        end else begin
          ctrl_d.reg_target = RT_NONE;
        end
      end
      default: ctrl_d.phase = phase_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctrl_q <= ctrl_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign phase_o          = ctrl_q.phase;
  assign ir_write_o       = ctrl_q.ir_write;
  assign alu_src_a_o      = ctrl_q.alu_src_a;
  assign alu_src_b_o      = ctrl_q.alu_src_b;
  assign alu_op_o         = ctrl_q.alu_op;
  assign pc_update_o      = ctrl_q.pc_update;
  assign pc_source_o      = ctrl_q.pc_source;
  assign addr_from_alu_o  = ctrl_q.addr_from_alu;
  assign mem_access_o     = ctrl_q.mem_access;
  assign reg_target_o     = ctrl_q.reg_target;
  assign write_from_mem_o = ctrl_q.write_from_mem;
  assign sign_extend_o    = ctrl_q.sign_extend;

`ifndef SYNTHESIS
  a_fetch_loads_ir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_FETCH) |=> (out_valid_o && ir_write_o && phase_o == PH_FETCH))
    else $error("fetch word without ir_write");

  a_decode_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && phase_o == PH_DECODE) |-> (sign_extend_o && alu_src_b_o == SRCB_IMMSH))
    else $error("decode word malformed");

  a_store_in_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mem_access_o == MEM_WRITE) |-> (addr_from_alu_o && phase_o == PH_MEM))
    else $error("store outside memory phase");

  a_decode_follows_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_FETCH) |=> (phase_q == PH_DECODE))
    else $error("phase did not advance to decode");
`endif

endmodule

// ===== bench/multicycle_cpu_control_fsm_tb.sv =====
`timescale 1ns / 100ps

module multicycle_cpu_control_fsm_tb;
  import mccf_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_word;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  phase;
  logic        ir_write;
  logic        alu_src_a;
  logic [1:0]  alu_src_b;
  logic [3:0]  alu_op;
  logic [1:0]  pc_update;
  logic [1:0]  pc_source;
  logic        addr_from_alu;
  logic [1:0]  mem_access;
  logic [1:0]  reg_target;
  logic        write_from_mem;
  logic        sign_extend;

  ctrl_t       ctrl_words_q[$];
  phase_e      mon_phase;
  phase_e      drv_phase;
  int unsigned err_cnt;
  int unsigned item_cnt;
  int unsigned idle_cycles;
  bit          sender_quiet;

  multicycle_cpu_control_fsm dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .instr_word_i     (in_word),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .phase_o          (phase),
    .ir_write_o       (ir_write),
    .alu_src_a_o      (alu_src_a),
    .alu_src_b_o      (alu_src_b),
    .alu_op_o         (alu_op),
    .pc_update_o      (pc_update),
    .pc_source_o      (pc_source),
    .addr_from_alu_o  (addr_from_alu),
    .mem_access_o     (mem_access),
    .reg_target_o     (reg_target),
    .write_from_mem_o (write_from_mem),
    .sign_extend_o    (sign_extend)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic alu_op_e funct_to_alu(input logic [5:0] fn);
    case (fn)
      FN_SLL:  return ALU_SLL;
      FN_SRL:  return ALU_SRL;
      FN_SRA:  return ALU_SRA;
      FN_ADDU: return ALU_ADD;
      FN_SUBU: return ALU_SUB;
      FN_AND:  return ALU_AND;
      FN_OR:   return ALU_OR;
      FN_XOR:  return ALU_XOR;
      FN_NOR:  return ALU_NOR;
      FN_SLT:  return ALU_SLT;
      FN_SLTU: return ALU_LTU;
      default: return ALU_NONE;
    endcase
  endfunction

  function automatic alu_op_e immop_to_alu(input logic [5:0] op);
    case (op)
      OP_ADD_IMM: return ALU_ADD;
      OP_SLTI:    return ALU_SLT;
      OP_LTU_IMM: return ALU_LTU;
      OP_ANDI:    return ALU_AND;
      OP_ORI:     return ALU_OR;
      OP_XORI:    return ALU_XOR;
      default:    return ALU_LUI;
    endcase
  endfunction

  // control word of one phase and the phase that follows it
  function automatic void decode_ctrl(input phase_e ph, input logic [31:0] w,
                                      output ctrl_t c, output phase_e nx);
    logic [5:0] op;
    logic [5:0] fn;
    op = w[31:26];
    fn = w[5:0];
    c = '0;
    c.phase = ph;
    nx = PH_FETCH;
    if (ph == PH_FETCH) begin
      c.ir_write   = 1'b1;
      c.alu_src_b  = SRCB_FOUR;
      c.alu_op     = ALU_ADD;
      c.pc_update  = PCU_ALWAYS;
      c.mem_access = MEM_READ;
      nx = PH_DECODE;
    end else if (ph == PH_DECODE) begin
      c.alu_src_b   = SRCB_IMMSH;
      c.alu_op      = ALU_ADD;
      c.sign_extend = 1'b1;
      nx = PH_EXEC;
    end else if (op == OP_SPECIAL) begin
      if (ph == PH_EXEC) begin
        c.alu_src_a = 1'b1;
        if (fn == FN_JR) begin
          c.pc_update = PCU_ALWAYS;
          c.pc_source = PCS_REG;
        end else begin
          c.alu_op = funct_to_alu(fn);
          nx = PH_WB;
        end
      end else if (ph == PH_WB && fn != FN_JR) begin
        c.reg_target = RT_RD;
      end
    end else if (op == OP_LW || op == OP_SW) begin
      if (ph == PH_EXEC) begin
        c.alu_src_a   = 1'b1;
        c.alu_src_b   = SRCB_IMM;
        c.alu_op      = ALU_ADD;
        c.sign_extend = 1'b1;
        nx = PH_MEM;
      end else if (ph == PH_MEM) begin
        c.addr_from_alu = 1'b1;
        if (op == OP_LW) begin
          c.mem_access = MEM_READ;
          nx = PH_WB;
        end else begin
          c.mem_access = MEM_WRITE;
        end
      end else if (ph == PH_WB && op == OP_LW) begin
        c.reg_target     = RT_RT;
        c.write_from_mem = 1'b1;
      end
    end else if (op == OP_BEQ || op == OP_BNE) begin
      if (ph == PH_EXEC) begin
        c.alu_src_a   = 1'b1;
        c.sign_extend = 1'b1;
        c.alu_op      = (op == OP_BEQ) ? ALU_EQ : ALU_NEQ;
        c.pc_update   = PCU_BRANCH;
        c.pc_source   = PCS_ALUOUT;
      end
    end else if (op == OP_J) begin
      if (ph == PH_EXEC) begin
        c.pc_update = PCU_ALWAYS;
        c.pc_source = PCS_JUMP;
      end
    end else if (op == OP_JAL) begin
      if (ph == PH_EXEC) begin
        c.pc_update = PCU_ALWAYS;
        c.pc_source = PCS_JUMP;
        nx = PH_WB;
      end else if (ph == PH_WB) begin
        c.reg_target = RT_RA;
      end
    end else if (op >= OP_ADD_IMM && op <= OP_LUI) begin
      if (ph == PH_EXEC) begin
        c.alu_src_a   = 1'b1;
        c.alu_src_b   = SRCB_IMM;
        c.sign_extend = (op == OP_ADD_IMM || op == OP_SLTI || op == OP_LTU_IMM);
        c.alu_op      = immop_to_alu(op);
        nx = PH_WB;
      end else if (ph == PH_WB) begin
        c.reg_target = RT_RT;
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // scoreboard, predictor and watchdog
  always @(posedge clk_i) begin
    ctrl_t  want;
    phase_e nx;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (ctrl_words_q.size() == 0) begin
          $error("control word with none pending");
          err_cnt++;
        end else begin
          want = ctrl_words_q.pop_front();
          check_field("phase", 4'(want.phase), 4'(phase));
          check_field("ir_write", 4'(want.ir_write), 4'(ir_write));
          check_field("alu_src_a", 4'(want.alu_src_a), 4'(alu_src_a));
          check_field("alu_src_b", 4'(want.alu_src_b), 4'(alu_src_b));
          check_field("alu_op", want.alu_op, alu_op);
          check_field("pc_update", 4'(want.pc_update), 4'(pc_update));
          check_field("pc_source", 4'(want.pc_source), 4'(pc_source));
          check_field("addr_from_alu", 4'(want.addr_from_alu), 4'(addr_from_alu));
          check_field("mem_access", 4'(want.mem_access), 4'(mem_access));
          check_field("reg_target", 4'(want.reg_target), 4'(reg_target));
          check_field("write_from_mem", 4'(want.write_from_mem), 4'(write_from_mem));
          check_field("sign_extend", 4'(want.sign_extend), 4'(sign_extend));
        end
      end
      if (in_valid && !in_stall) begin
        decode_ctrl(mon_phase, in_word, want, nx);
        ctrl_words_q.push_back(want);
        mon_phase = nx;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned free_len;
    int unsigned stall_len;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      free_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
      stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      repeat (free_len) begin
        @(negedge clk_i);
        out_stall <= 1'b0;
      end
      repeat (stall_len) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    ctrl_t       c;
    phase_e      nx;
    gap = rand_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    decode_ctrl(drv_phase, w, c, nx);
    drv_phase = nx;
    item_cnt++;
  endtask

  // hold one word until the machine is back in fetch
  task automatic send_instr(input logic [31:0] w);
    do send_word(w); while (drv_phase != PH_FETCH);
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (ctrl_words_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    logic [5:0]  op;
    w = $urandom;
    case ($urandom_range(0, 12))
      0, 1, 2: begin
        w[31:26] = OP_SPECIAL;
        case ($urandom_range(0, 10))
          0:  w[5:0] = FN_SLL;
          1:  w[5:0] = FN_SRL;
          2:  w[5:0] = FN_SRA;
          3:  w[5:0] = FN_ADDU;
          4:  w[5:0] = FN_SUBU;
          5:  w[5:0] = FN_AND;
          6:  w[5:0] = FN_OR;
          7:  w[5:0] = FN_XOR;
          8:  w[5:0] = FN_NOR;
          9:  w[5:0] = FN_SLT;
          default: w[5:0] = FN_SLTU;
        endcase
      end
      3: begin
        w[31:26] = OP_SPECIAL;
        w[5:0]   = FN_JR;
      end
      4:  w[31:26] = OP_SPECIAL;
      5:  w[31:26] = OP_LW;
      6:  w[31:26] = OP_SW;
      7:  w[31:26] = OP_BEQ;
      8:  w[31:26] = OP_BNE;
      9:  w[31:26] = OP_J;
      10: w[31:26] = OP_JAL;
      11: w[31:26] = 6'($urandom_range(OP_ADD_IMM, OP_LUI));
      default: begin
        do op = 6'($urandom);
        while (op inside {OP_SPECIAL, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_LW, OP_SW}
               || (op >= OP_ADD_IMM && op <= OP_LUI));
        w[31:26] = op;
      end
    endcase
    return w;
  endfunction

  task automatic test_directed_instrs();
    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    send_instr({OP_LW, 5'd31, 5'd1, 16'h8000});
    send_instr({OP_SW, 5'd0, 5'd31, 16'h7FFF});
    send_instr({OP_BEQ, 5'd3, 5'd4, 16'hFFFF});
    send_instr({OP_JAL, 26'h3FF_FFFF});
  endtask

  // word changes mid-instruction: memory phase without load/store, writeback for a store
  task automatic test_broken_sequences();
    repeat (3) send_word({OP_LW, 26'h155_5555});
    send_word({OP_SPECIAL, 20'hAAAAA, FN_ADDU});
    repeat (3) send_word({OP_SPECIAL, 20'h0F0F0, FN_SUBU});
    send_word({OP_SW, 26'h2AA_AAAA});
  endtask

  task automatic test_random_programs(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned n_instr;
    stop_at = item_cnt + n_items;
    n_instr = 0;
    while (item_cnt < stop_at) begin
      if (n_instr % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) send_word(random_instr());
        if (drv_phase != PH_FETCH) send_instr(random_instr());
      end else begin
        send_instr(random_instr());
      end
      if ($urandom_range(0, 99) == 0) wait_all_results();
      n_instr++;
    end
    sender_quiet = 1'b0;
  endtask

  task automatic test_random_noise(input int unsigned n_items);
    repeat (n_items) send_word($urandom);
    if (drv_phase != PH_FETCH) send_instr(random_instr());
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    mon_phase    = PH_FETCH;
    drv_phase    = PH_FETCH;
    err_cnt      = 0;
    item_cnt     = 0;
    idle_cycles  = 0;
    sender_quiet = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_instrs();
    wait_all_results();
    test_broken_sequences();
    wait_all_results();
    test_random_programs(1500);
    wait_all_results();
    test_random_noise(400);
    wait_all_results();
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
